// ===== rtl/core/bit_count_unit_macros.svh =====
// Assertion macros for the bit count unit RTL.
`ifndef BIT_COUNT_UNIT_MACROS_SVH
`define BIT_COUNT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BCU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BCU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bcu_pkg.sv =====
// Types and constants for the bit count unit.
package bcu_pkg;

  localparam int unsigned OPND_W = 64;
  localparam int unsigned CNT_W  = 7;

  typedef enum logic [3:0] {
    OP_LZCNT   = 4'd0,
    OP_LONES   = 4'd1,
    OP_TZCNT   = 4'd2,
    OP_TONES   = 4'd3,
    OP_POPCNT  = 4'd4,
    OP_ZEROCNT = 4'd5,
    OP_SINGLE  = 4'd6,
    OP_WIDTH   = 4'd7,
    OP_FLOOR   = 4'd8,
    OP_CEIL    = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    SZ_8  = 2'd0,
    SZ_16 = 2'd1,
    SZ_32 = 2'd2,
    SZ_64 = 2'd3
  } size_t;

  typedef struct packed {
    op_t                opcode;
    size_t              size_sel;
    logic [OPND_W-1:0]  operand;
  } in_item_t;

  typedef struct packed {
    logic [OPND_W-1:0]  result;
    logic               ceil_overflow;
  } out_item_t;

  // ones in each nibble value
  localparam logic [2:0] NIB_ONES [16] = '{
    3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
    3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
  };

endpackage

// ===== rtl/core/bcu_tzc.sv =====
// Trailing zero counter over a 64-bit word.
module bcu_tzc (
  input  logic [bcu_pkg::OPND_W-1:0] x,
  output logic [bcu_pkg::CNT_W-2:0]  idx,
  output logic                       zero
);
  import bcu_pkg::*;

  logic [OPND_W-1:0] low;

  // isolate the lowest set bit, then encode its position
  assign low  = x & (~x + OPND_W'(1));
  assign zero = (x == '0);

  always_comb begin
    idx = '0;
    for (int i = 0; i < OPND_W; i++) begin
      if (low[i]) begin
        idx = idx | (CNT_W-1)'(i);
      end
    end
  end

endmodule

// ===== rtl/core/bcu_popcnt.sv =====
// Population count of a 64-bit word as a nibble table and adder tree.
module bcu_popcnt (
  input  logic [bcu_pkg::OPND_W-1:0] x,
  output logic [bcu_pkg::CNT_W-1:0]  cnt
);
  import bcu_pkg::*;

  logic [2:0] l0 [16];
  logic [3:0] l1 [8];
  logic [4:0] l2 [4];
  logic [5:0] l3 [2];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      l0[i] = NIB_ONES[x[4*i +: 4]];
    end
    for (int i = 0; i < 8; i++) begin
      l1[i] = 4'(l0[2*i]) + 4'(l0[2*i+1]);
    end
    for (int i = 0; i < 4; i++) begin
      l2[i] = 5'(l1[2*i]) + 5'(l1[2*i+1]);
    end
    for (int i = 0; i < 2; i++) begin
      l3[i] = 6'(l2[2*i]) + 6'(l2[2*i+1]);
    end
    cnt = 7'(l3[0]) + 7'(l3[1]);
  end

endmodule

// ===== rtl/core/bcu_core.sv =====
// Combinational datapath: masks the operand and forms the selected bit utility.
module bcu_core (
  input  bcu_pkg::in_item_t  item,
  output bcu_pkg::out_item_t res
);
  import bcu_pkg::*;

  logic [CNT_W-1:0]  bits;
  logic [OPND_W-1:0] mask;
  logic [5:0]        align_sh;
  logic [OPND_W-1:0] v;
  logic [OPND_W-1:0] nv;
  logic [OPND_W-1:0] lead_src;
  logic [OPND_W-1:0] lead_aligned;
  logic [OPND_W-1:0] lead_rev;
  logic [OPND_W-1:0] trail_src;
  logic [CNT_W-2:0]  lead_idx;
  logic              lead_zero;
  logic [CNT_W-2:0]  trail_idx;
  logic              trail_zero;
  logic [CNT_W-1:0]  lead_cnt;
  logic [CNT_W-1:0]  trail_cnt;
  logic [CNT_W-1:0]  pop;
  logic [CNT_W-1:0]  w;
  logic              single;

  always_comb begin
    unique case (item.size_sel)
      SZ_8: begin
        bits = 7'd8;  mask = 64'h0000_0000_0000_00ff; align_sh = 6'd56;
      end
      SZ_16: begin
        bits = 7'd16; mask = 64'h0000_0000_0000_ffff; align_sh = 6'd48;
      end
      SZ_32: begin
        bits = 7'd32; mask = 64'h0000_0000_ffff_ffff; align_sh = 6'd32;
      end
      SZ_64: begin
        bits = 7'd64; mask = 64'hffff_ffff_ffff_ffff; align_sh = 6'd0;
      end
      default: begin
        bits = 7'd64; mask = 64'hffff_ffff_ffff_ffff; align_sh = 6'd0;
      end
    endcase
  end

  assign v  = item.operand & mask;
  assign nv = ~item.operand & mask;

  // leading count: top-align the field, reverse, count trailing zeros
  assign lead_src     = (item.opcode == OP_LONES) ? nv : v;
  assign lead_aligned = lead_src << align_sh;
  always_comb begin
    for (int i = 0; i < OPND_W; i++) begin
      lead_rev[i] = lead_aligned[OPND_W-1-i];
    end
  end
  assign trail_src = (item.opcode == OP_TONES) ? nv : v;

  bcu_tzc u_lead (.x(lead_rev),  .idx(lead_idx),  .zero(lead_zero));
  bcu_tzc u_trail (.x(trail_src), .idx(trail_idx), .zero(trail_zero));
  bcu_popcnt u_pop (.x(v), .cnt(pop));

  assign lead_cnt  = lead_zero  ? bits : {1'b0, lead_idx};
  assign trail_cnt = trail_zero ? bits : {1'b0, trail_idx};
  // lead unit sees v for every opcode that needs the width
  assign w      = bits - lead_cnt;
  assign single = (pop == 7'd1);

  always_comb begin
    res.result        = '0;
    res.ceil_overflow = 1'b0;
    unique case (item.opcode)
      OP_LZCNT, OP_LONES: res.result = OPND_W'(lead_cnt);
      OP_TZCNT, OP_TONES: res.result = OPND_W'(trail_cnt);
      OP_POPCNT:          res.result = OPND_W'(pop);
      OP_ZEROCNT:         res.result = OPND_W'(bits - pop);
      OP_SINGLE:          res.result = OPND_W'(single);
      OP_WIDTH:           res.result = OPND_W'(w);
      OP_FLOOR: begin
        if (!lead_zero) begin
          res.result = OPND_W'(1) << w[5:0] - 6'd1;
        end
      end
      OP_CEIL: begin
        if (v <= OPND_W'(1)) begin
          res.result = OPND_W'(1);
        end else if (single) begin
          res.result = v;
        end else if (w >= bits) begin
          res.ceil_overflow = 1'b1;
        end else begin
          res.result = OPND_W'(1) << w[5:0];
        end
      end
      default: begin
        res.result        = '0;
        res.ceil_overflow = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/bit_count_unit.sv =====
// Top level of the bit count unit: input register, datapath, result register.
`include "bit_count_unit_macros.svh"

// Bit count unit: one beat in, one beat out, for lzcnt/lones/tzcnt/tones,
// popcnt, zero count, single-bit test, bit width, bit floor and bit ceiling
// on an 8, 16, 32 or 64-bit operand. Throughput is one beat per cycle while
// out_stall is low. An accepted beat is held in the input register, and its
// result in the result register, with the bit utility computed in the single
// combinational stage between them. While a result waits under out_stall,
// the input register still takes one more beat before in_stall rises.
module bit_count_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bcu_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bcu_pkg::out_item_t  out_data
);
  import bcu_pkg::*;

  in_item_t  s1_r,     s1_nxt;
  logic      s1_v_r,   s1_v_nxt;
  out_item_t out_r,    out_nxt;
  logic      out_v_r,  out_v_nxt;
  out_item_t core_res;
  logic      out_free;
  logic      s1_free;
  logic      s1_adv;

  bcu_core u_core (.item(s1_r), .res(core_res));

  assign out_free = !out_v_r || !out_stall;
  assign s1_adv   = s1_v_r && out_free;
  assign s1_free  = !s1_v_r || out_free;
  assign in_stall = !s1_free;

  always_comb begin
    s1_nxt    = s1_r;
    s1_v_nxt  = s1_v_r;
    out_nxt   = out_r;
    out_v_nxt = out_v_r;
    if (out_free) begin
      out_v_nxt = s1_v_r;
      if (s1_v_r) begin
        out_nxt = core_res;
      end
    end
    if (s1_free) begin
      s1_v_nxt = in_valid;
      if (in_valid) begin
        s1_nxt = in_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
    s1_r  <= s1_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  `BCU_ASSERT_NOW(a_stall_full, in_stall, s1_v_r && out_v_r && out_stall, "stall while not full")
  `BCU_ASSERT_NEXT(a_adv_valid, s1_adv, out_v_r, "advanced beat lost")
  `BCU_ASSERT_NEXT(a_drain, out_v_r && !out_stall && !s1_v_r, !out_v_r, "result repeated")
  `BCU_ASSERT_NOW(a_ovf_zero, out_v_r && out_r.ceil_overflow, out_r.result == '0,
                  "overflow with nonzero result")

endmodule
